// ----- rtl/scbd_pkg.sv -----
// Shared types and constants for the sound CPU bus decoder.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package scbd_pkg;

   typedef enum logic [2:0] {
      FUNC_CPU_RD  = 3'd0,
      FUNC_CPU_WR  = 3'd1,
      FUNC_CTRL_WR = 3'd2,
      FUNC_CTRL_RD = 3'd3,
      FUNC_IRQ     = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      DEST_RAM  = 3'd0,
      DEST_FM   = 3'd1,
      DEST_BANK = 3'd2,
      DEST_PSG  = 3'd3,
      DEST_HOST = 3'd4,
      DEST_NONE = 3'd5,
      DEST_CTRL = 3'd6
   } dest_type;

   localparam int FUNC_W      = 3;
   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int DEST_W      = 3;
   localparam int DEST_ADDR_W = 24;
   localparam int BANK_W      = 9;
   localparam int RAM_AW      = 13;
   localparam int WIN_AW      = 15;

   localparam logic [ADDR_W-1:0] ADDR_FM_BASE   = 16'h4000;
   localparam logic [ADDR_W-1:0] ADDR_BANK_REG  = 16'h6000;
   localparam logic [ADDR_W-1:0] ADDR_PSG       = 16'h7F11;
   localparam logic [ADDR_W-1:0] CTRL_BUSREQ    = 16'h1100;
   localparam logic [ADDR_W-1:0] CTRL_RESET     = 16'h1200;
   localparam logic [ADDR_W-1:0] CTRL_BUSREQ_HI = 16'h1101;
   localparam logic [ADDR_W-1:0] CTRL_RESET_HI  = 16'h1201;
   localparam logic [DATA_W-1:0] OPEN_BUS       = 8'hFF;

endpackage

`default_nettype wire

// ----- rtl/scbd_if.sv -----
// Valid/ready channel interfaces for the sound CPU bus decoder.
// Depends on scbd_pkg for field widths.
`default_nettype none

interface scbd_req_if import scbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] data;

   modport source (output valid, output func, output addr, output data, input ready);
   modport sink   (input valid, input func, input addr, input data, output ready);
endinterface

interface scbd_rsp_if import scbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [DEST_W-1:0]      dest;
   logic [DEST_ADDR_W-1:0] dest_addr;
   logic                   is_write;
   logic [DATA_W-1:0]      data_out;
   logic                   running;
   logic                   irq_pending;
   logic                   reset_pulse;

   modport source (output valid, output dest, output dest_addr, output is_write,
                   output data_out, output running, output irq_pending,
                   output reset_pulse, input ready);
   modport sink   (input valid, input dest, input dest_addr, input is_write,
                   input data_out, input running, input irq_pending,
                   input reset_pulse, output ready);
endinterface

`default_nettype wire

// ----- rtl/sound_cpu_bus_decoder.sv -----
// Sound CPU bus decoder top level: input register, decode, result register.
// Depends on scbd_pkg and the channel interfaces in scbd_if.sv.
//
// Each request transaction is one sound CPU read or write, one host control
// access, or an irq level change; it yields exactly one response transaction
// naming the destination (RAM, FM chip, bank register, PSG, banked host
// window, control, or none), the address and data passed on, and the CPU
// running and irq state after the access. A request is taken every cycle
// the response side keeps up; it is held in the input register while the
// decode logic works out its response and the new bank and CPU control
// state, and both are stored in the result and state registers when the
// response side can take them. Reset leaves the bank at zero and the CPU
// held in reset until the first nonzero write to the reset control.
`default_nettype none

module sound_cpu_bus_decoder import scbd_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   scbd_req_if.sink   req_chan,
   scbd_rsp_if.source rsp_chan
);

   logic              in_valid_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] data_ff;

   logic              out_valid_ff;
   logic              advance;

   logic [BANK_W-1:0] bank_ff, bank_in;
   logic              held_ff, held_in;
   logic              in_reset_ff, in_reset_in;
   logic              released_ff, released_in;
   logic              irq_ff, irq_in;

   dest_type               dest_in;
   logic [DEST_ADDR_W-1:0] dest_addr_in;
   logic                   is_write_in;
   logic [DATA_W-1:0]      data_out_in;
   logic                   pulse_in;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;

   always_comb begin
      bank_in      = bank_ff;
      held_in      = held_ff;
      in_reset_in  = in_reset_ff;
      released_in  = released_ff;
      irq_in       = irq_ff;
      dest_in      = DEST_NONE;
      dest_addr_in = '0;
      is_write_in  = 1'b0;
      data_out_in  = '0;
      pulse_in     = 1'b0;
      case (func_ff)
         FUNC_CPU_RD: begin
            if (addr_ff < ADDR_FM_BASE) begin
               dest_in      = DEST_RAM;
               dest_addr_in = {{(DEST_ADDR_W-RAM_AW){1'b0}}, addr_ff[RAM_AW-1:0]};
            end else if (addr_ff < ADDR_BANK_REG) begin
               dest_in = DEST_FM;
            end else if (addr_ff[ADDR_W-1]) begin
               dest_in      = DEST_HOST;
               dest_addr_in = {bank_ff, addr_ff[WIN_AW-1:0]};
            end else begin
               data_out_in = OPEN_BUS;
            end
         end
         FUNC_CPU_WR: begin
            is_write_in = 1'b1;
            data_out_in = data_ff;
            if (addr_ff < ADDR_FM_BASE) begin
               dest_in      = DEST_RAM;
               dest_addr_in = {{(DEST_ADDR_W-RAM_AW){1'b0}}, addr_ff[RAM_AW-1:0]};
            end else if (addr_ff < ADDR_BANK_REG) begin
               dest_in      = DEST_FM;
               dest_addr_in = {{(DEST_ADDR_W-2){1'b0}}, addr_ff[1:0]};
            end else if (addr_ff == ADDR_BANK_REG) begin
               dest_in = DEST_BANK;
               bank_in = {data_ff[0], bank_ff[BANK_W-1:1]};
            end else if (addr_ff == ADDR_PSG) begin
               dest_in = DEST_PSG;
            end else if (addr_ff[ADDR_W-1]) begin
               dest_in      = DEST_HOST;
               dest_addr_in = {bank_ff, addr_ff[WIN_AW-1:0]};
            end else begin
               is_write_in = 1'b0;
               data_out_in = '0;
            end
         end
         FUNC_CTRL_WR: begin
            dest_in      = DEST_CTRL;
            dest_addr_in = {{(DEST_ADDR_W-ADDR_W){1'b0}}, addr_ff};
            is_write_in  = 1'b1;
            data_out_in  = data_ff;
            if (addr_ff == CTRL_BUSREQ) begin
               held_in = |data_ff;
            end else if (addr_ff == CTRL_RESET) begin
               if (data_ff == '0) begin
                  in_reset_in = 1'b1;
               end else begin
                  in_reset_in = 1'b0;
                  released_in = 1'b1;
                  irq_in      = 1'b0;
                  pulse_in    = 1'b1;
               end
            end
         end
         FUNC_CTRL_RD: begin
            dest_in      = DEST_CTRL;
            dest_addr_in = {{(DEST_ADDR_W-ADDR_W){1'b0}}, addr_ff};
            if (addr_ff == CTRL_BUSREQ) begin
               data_out_in = {{(DATA_W-1){1'b0}}, !held_ff};
            end else if (addr_ff == CTRL_RESET) begin
               data_out_in = {{(DATA_W-1){1'b0}}, in_reset_ff};
            end else if (addr_ff inside {CTRL_BUSREQ_HI, CTRL_RESET_HI}) begin
               data_out_in = '0;
            end else begin
               data_out_in = OPEN_BUS;
            end
         end
         FUNC_IRQ: begin
            if (released_ff) begin
               irq_in = |data_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bank_ff      <= '0;
         held_ff      <= 1'b0;
         in_reset_ff  <= 1'b1;
         released_ff  <= 1'b0;
         irq_ff       <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               bank_ff     <= bank_in;
               held_ff     <= held_in;
               in_reset_ff <= in_reset_in;
               released_ff <= released_in;
               irq_ff      <= irq_in;
            end
         end
      end
   end

   // hold payload registers unless a transaction moves in
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         func_ff <= req_chan.func;
         addr_ff <= req_chan.addr;
         data_ff <= req_chan.data;
      end
      if (advance && in_valid_ff) begin
         rsp_chan.dest        <= dest_in;
         rsp_chan.dest_addr   <= dest_addr_in;
         rsp_chan.is_write    <= is_write_in;
         rsp_chan.data_out    <= data_out_in;
         rsp_chan.running     <= released_in && !held_in && !in_reset_in;
         rsp_chan.irq_pending <= irq_in;
         rsp_chan.reset_pulse <= pulse_in;
      end
   end

endmodule

`default_nettype wire

// ----- dv/sound_cpu_bus_decoder_test.sv -----
// Testbench for sound_cpu_bus_decoder. It drives directed and random bus
// accesses with random stalls on both channels and checks every response.
// Depends on scbd_pkg, the channel interfaces in scbd_if.sv and the RTL top.
module sound_cpu_bus_decoder_test import scbd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int STEADY_ITEMS  = 250;
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      dest_type               dest;
      logic [DEST_ADDR_W-1:0] dest_addr;
      logic                   is_write;
      logic [DATA_W-1:0]      data_out;
      logic                   running;
      logic                   irq_pending;
      logic                   reset_pulse;
   } bus_result_type;

   class decode_tracker;
      logic [BANK_W-1:0] bank;
      logic              bus_held;
      logic              in_reset;
      logic              released_once;
      logic              irq_latch;
      bus_result_type    pending_results[$];
      int                mismatches;

      function new();
         bank          = '0;
         bus_held      = 1'b0;
         in_reset      = 1'b1;
         released_once = 1'b0;
         irq_latch     = 1'b0;
         mismatches    = 0;
      endfunction

      function void note_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                 logic [DATA_W-1:0] d);
         bus_result_type r;
         r.dest        = DEST_NONE;
         r.dest_addr   = '0;
         r.is_write    = 1'b0;
         r.data_out    = '0;
         r.reset_pulse = 1'b0;
         case (f)
            FUNC_CPU_RD: begin
               if (a < ADDR_FM_BASE) begin
                  r.dest      = DEST_RAM;
                  r.dest_addr = {{(DEST_ADDR_W-RAM_AW){1'b0}}, a[RAM_AW-1:0]};
               end else if (a < ADDR_BANK_REG) begin
                  r.dest = DEST_FM;
               end else if (a[ADDR_W-1]) begin
                  r.dest      = DEST_HOST;
                  r.dest_addr = {bank, a[WIN_AW-1:0]};
               end else begin
                  r.data_out = OPEN_BUS;
               end
            end
            FUNC_CPU_WR: begin
               r.is_write = 1'b1;
               r.data_out = d;
               if (a < ADDR_FM_BASE) begin
                  r.dest      = DEST_RAM;
                  r.dest_addr = {{(DEST_ADDR_W-RAM_AW){1'b0}}, a[RAM_AW-1:0]};
               end else if (a < ADDR_BANK_REG) begin
                  r.dest      = DEST_FM;
                  r.dest_addr = {{(DEST_ADDR_W-2){1'b0}}, a[1:0]};
               end else if (a == ADDR_BANK_REG) begin
                  r.dest = DEST_BANK;
                  bank   = {d[0], bank[BANK_W-1:1]};
               end else if (a == ADDR_PSG) begin
                  r.dest = DEST_PSG;
               end else if (a[ADDR_W-1]) begin
                  r.dest      = DEST_HOST;
                  r.dest_addr = {bank, a[WIN_AW-1:0]};
               end else begin
                  r.is_write = 1'b0;
                  r.data_out = '0;
               end
            end
            FUNC_CTRL_WR: begin
               r.dest      = DEST_CTRL;
               r.dest_addr = {{(DEST_ADDR_W-ADDR_W){1'b0}}, a};
               r.is_write  = 1'b1;
               r.data_out  = d;
               if (a == CTRL_BUSREQ) begin
                  bus_held = |d;
               end else if (a == CTRL_RESET) begin
                  if (d == '0) begin
                     in_reset = 1'b1;
                  end else begin
                     in_reset      = 1'b0;
                     released_once = 1'b1;
                     irq_latch     = 1'b0;
                     r.reset_pulse = 1'b1;
                  end
               end
            end
            FUNC_CTRL_RD: begin
               r.dest      = DEST_CTRL;
               r.dest_addr = {{(DEST_ADDR_W-ADDR_W){1'b0}}, a};
               if (a == CTRL_BUSREQ)
                  r.data_out = {{(DATA_W-1){1'b0}}, ~bus_held};
               else if (a == CTRL_RESET)
                  r.data_out = {{(DATA_W-1){1'b0}}, in_reset};
               else if (a == CTRL_BUSREQ_HI || a == CTRL_RESET_HI)
                  r.data_out = '0;
               else
                  r.data_out = OPEN_BUS;
            end
            FUNC_IRQ: begin
               if (released_once)
                  irq_latch = |d;
            end
            default: begin
            end
         endcase
         r.running     = released_once && !bus_held && !in_reset;
         r.irq_pending = irq_latch;
         pending_results.push_back(r);
      endfunction

      function void check_response(bus_result_type got);
         bus_result_type want;
         if (pending_results.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected response: dest %0d addr %h data %h",
                        got.dest, got.dest_addr, got.data_out);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.dest !== want.dest || got.dest_addr !== want.dest_addr ||
                got.is_write !== want.is_write || got.data_out !== want.data_out ||
                got.running !== want.running || got.irq_pending !== want.irq_pending ||
                got.reset_pulse !== want.reset_pulse) begin
               if (mismatches < MAX_REPORTS) begin
                  $display({"mismatch expected: dest %0d addr %h wr %b data %h",
                            " run %b irq %b pulse %b"},
                           want.dest, want.dest_addr, want.is_write, want.data_out,
                           want.running, want.irq_pending, want.reset_pulse);
                  $display({"         actual:   dest %0d addr %h wr %b data %h",
                            " run %b irq %b pulse %b"},
                           got.dest, got.dest_addr, got.is_write, got.data_out,
                           got.running, got.irq_pending, got.reset_pulse);
               end
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic steady_tail;
   decode_tracker tracker;

   scbd_req_if req_bus ();
   scbd_rsp_if rsp_bus ();

   sound_cpu_bus_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!steady_tail && $urandom_range(5, 0) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      bus_result_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.dest        = dest_type'(rsp_bus.dest);
            got.dest_addr   = rsp_bus.dest_addr;
            got.is_write    = rsp_bus.is_write;
            got.data_out    = rsp_bus.data_out;
            got.running     = rsp_bus.running;
            got.irq_pending = rsp_bus.irq_pending;
            got.reset_pulse = rsp_bus.reset_pulse;
            tracker.check_response(got);
         end
         if (req_bus.valid && req_bus.ready)
            tracker.note_request(req_bus.func, req_bus.addr, req_bus.data);
      end
   end

   task automatic send_access(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
      @(negedge clock);
      if (!steady_tail && $urandom_range(7, 0) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= f;
      req_bus.addr  <= a;
      req_bus.data  <= d;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] pick_cpu_addr();
      case ($urandom_range(6, 0))
         0: return ADDR_W'($urandom_range(16'h3FFF, 16'h0000));
         1: return ADDR_W'($urandom_range(16'h5FFF, 16'h4000));
         2: return ADDR_BANK_REG;
         3: return ADDR_PSG;
         4: return ADDR_W'($urandom_range(16'h7FFF, 16'h6000));
         5: return ADDR_W'($urandom_range(16'hFFFF, 16'h8000));
         default: return ADDR_W'($urandom_range(16'hFFFF, 16'h0000));
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_ctrl_offset();
      case ($urandom_range(5, 0))
         0, 1: return CTRL_BUSREQ;
         2:    return CTRL_RESET;
         3:    return CTRL_BUSREQ_HI;
         4:    return CTRL_RESET_HI;
         default: return ADDR_W'($urandom_range(16'hFFFF, 16'h0000));
      endcase
   endfunction

   task automatic send_random_access();
      int                pick;
      logic [DATA_W-1:0] d;
      pick = $urandom_range(99, 0);
      d    = DATA_W'($urandom_range(8'hFF, 8'h00));
      if (pick < 25)
         send_access(FUNC_CPU_RD, pick_cpu_addr(), d);
      else if (pick < 50)
         send_access(FUNC_CPU_WR, pick_cpu_addr(), d);
      else if (pick < 58)
         send_access(FUNC_CPU_WR, ADDR_BANK_REG, d);
      else if (pick < 62)
         send_access(FUNC_CTRL_WR, CTRL_RESET,
                     ($urandom_range(3, 0) == 0) ? '0 : d);
      else if (pick < 70)
         send_access(FUNC_CTRL_WR, pick_ctrl_offset(),
                     ($urandom_range(1, 0) == 0) ? '0 : d);
      else if (pick < 80)
         send_access(FUNC_CTRL_RD, pick_ctrl_offset(), d);
      else if (pick < 94)
         send_access(FUNC_IRQ, ADDR_W'($urandom_range(16'hFFFF, 16'h0000)),
                     ($urandom_range(1, 0) == 0) ? '0 : d);
      else
         send_access(FUNC_W'($urandom_range(FUNC_UNUSED_HI, 0)),
                     ADDR_W'($urandom_range(16'hFFFF, 16'h0000)), d);
   endtask

   initial begin
      tracker       = new();
      steady_tail   = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func  = FUNC_CPU_RD;
      req_bus.addr  = '0;
      req_bus.data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_access(FUNC_CPU_RD, 16'h0000, 8'h5A);
      send_access(FUNC_CPU_RD, 16'h3FFF, 8'h00);
      send_access(FUNC_IRQ, 16'h0000, 8'hFF);
      send_access(FUNC_CTRL_RD, CTRL_RESET, 8'h00);
      send_access(FUNC_CTRL_WR, CTRL_RESET, 8'h01);
      send_access(FUNC_IRQ, 16'hFFFF, 8'h80);
      send_access(FUNC_CTRL_WR, CTRL_RESET, 8'h00);
      send_access(FUNC_CTRL_RD, CTRL_RESET, 8'hFF);
      send_access(FUNC_CTRL_WR, CTRL_RESET, 8'hFF);
      send_access(FUNC_CTRL_WR, CTRL_BUSREQ, 8'h10);
      send_access(FUNC_CTRL_RD, CTRL_BUSREQ, 8'h00);
      send_access(FUNC_CTRL_RD, CTRL_BUSREQ_HI, 8'h00);
      send_access(FUNC_CTRL_RD, CTRL_RESET_HI, 8'h00);
      send_access(FUNC_CTRL_RD, 16'hFFFF, 8'h00);
      send_access(FUNC_CTRL_WR, CTRL_BUSREQ, 8'h00);
      send_access(FUNC_CTRL_WR, 16'h0000, 8'hA5);
      send_access(FUNC_CPU_WR, ADDR_BANK_REG, 8'h01);
      send_access(FUNC_CPU_WR, ADDR_BANK_REG, 8'hFE);
      send_access(FUNC_CPU_RD, 16'h8000, 8'h00);
      send_access(FUNC_CPU_WR, 16'hFFFF, 8'hFF);
      send_access(FUNC_CPU_RD, ADDR_FM_BASE, 8'h00);
      send_access(FUNC_CPU_WR, 16'h5FFF, 8'h00);
      send_access(FUNC_CPU_RD, ADDR_PSG, 8'h00);
      send_access(FUNC_CPU_WR, ADDR_PSG, 8'h3C);
      send_access(FUNC_CPU_WR, 16'h6001, 8'h77);
      send_access(FUNC_CPU_RD, ADDR_BANK_REG, 8'h00);
      send_access(FUNC_IRQ, 16'h0000, 8'h00);
      send_access(FUNC_UNUSED_LO, 16'h1200, 8'h01);
      send_access(FUNC_UNUSED_HI, 16'h6000, 8'hFF);

      drain_results();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2)
            drain_results();
         if (i == RANDOM_ITEMS - STEADY_ITEMS)
            steady_tail = 1'b1;
         send_random_access();
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sound_cpu_bus_decoder.f -----
rtl/scbd_pkg.sv
rtl/scbd_if.sv
rtl/sound_cpu_bus_decoder.sv
dv/sound_cpu_bus_decoder_test.sv
